// File: rtl/core/spt_pkg.sv
// Shared types, codes and constants for the sparsity pattern table.
// No dependencies; imported by every module of the block except spt_ram.
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

    // default sizes of the stores
    localparam int DEF_MAX_ROWS  = 256;
    localparam int DEF_MAX_COLS  = 256;
    localparam int DEF_MAX_SLOTS = 16;

    // field widths fixed by the interface
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 8;
    localparam int POS_W   = 13;
    localparam int BAND_W  = 8;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 9;
    localparam int SLOT_CFG_W = 5;
    localparam int CFG_ADDR_W = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOTS = 2'd2;

    // register values after reset
    localparam logic [CFG_W-1:0]      RST_ROWS  = 9'd256;
    localparam logic [CFG_W-1:0]      RST_COLS  = 9'd256;
    localparam logic [SLOT_CFG_W-1:0] RST_SLOTS = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR    = 3'd0,
        MODE_ADD      = 3'd1,
        MODE_LOOKUP   = 3'd2,
        MODE_COMPRESS = 3'd3,
        MODE_BAND     = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_RS0,
        S_RS1,
        S_RS2,
        S_RD,
        S_CHK,
        S_BW_ROW,
        S_BW_HI,
        S_BW_RD,
        S_BW_CHK,
        S_CP_ROW,
        S_CP_HI,
        S_CP_RD,
        S_CP_CHK,
        S_CP_WRS,
        S_CP_WR,
        S_CP_END,
        S_DONE
    } state_t;

    // which row_start entry is read
    typedef enum logic [1:0] {
        RS_ROW,
        RS_ROW1,
        RS_R1
    } rs_sel_t;

    // what the staged result becomes
    typedef enum logic [2:0] {
        RK_NONE,
        RK_ZERO,
        RK_RANGE_ADD,
        RK_RANGE_LOOKUP,
        RK_FULL,
        RK_HIT,
        RK_MISS,
        RK_BAND
    } res_kind_t;

    typedef struct packed {
        logic      load_item;
        logic      clr_start;
        logic      clr_step;
        rs_sel_t   rs_sel;
        logic      lo_ld;
        logic      hi_ld;
        logic      a_inc;
        logic      row_next;
        logic      add_write;
        logic      best_upd;
        logic      tmp_insert;
        logic      cp_wrs;
        logic      cp_wr;
        logic      cp_end;
        res_kind_t res_kind;
        logic      out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic range_ok;
        logic scan_end;
        logic slot_valid;
        logic col_hit;
        logic diag_hit;
        logic row_end;
        logic tmp_done;
        logic packed_set;
        logic out_free;
    } dp_stat_t;

    // clamp a register value to [1, hi]
    function automatic logic [15:0] clamp16(input logic [15:0] v, input logic [15:0] hi);
        logic [15:0] r;
        r = v;
        if (v == 16'd0)
        begin
            r = 16'd1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sparsity_pattern_table.sv
// Sparsity pattern table: compressed-row store of column numbers per row,
// with clear, add, lookup, compress and bandwidth requests. Top level;
// depends on spt_pkg, spt_ctrl, spt_datapath and spt_ram.
//
// One request at a time is worked on; the column store is a RAM with one
// write port and one registered read port, so each scanned slot takes an
// address step and a compare step. An add scans its row up to a match or
// the first free slot, a lookup up to a match, and both stop at the end of
// the row; an index out of range ends the request before any scan. A clear
// writes every slot of the active rows once. A bandwidth request reads the
// occupied slots of each row. A compress sorts each row and writes it back,
// the diagonal first on a square table; a repeated compress ends without a
// scan and an unused mode ends at once. After reset the block runs the same
// clearing pass with the reset register values and does not take requests
// until it is done; configuration writes are taken at any time but act only
// at the next clear. A finished result sits in an output register, so the
// next request is taken while the result still waits to be read. Register
// values of zero count as one and values above the store size are clamped.
`timescale 1ns / 1ps
`default_nettype none

module sparsity_pattern_table #(
    parameter int MAX_ROWS  = spt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = spt_pkg::DEF_MAX_COLS,
    parameter int MAX_SLOTS = spt_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration writes: 0 num_rows, 1 num_cols, 2 slots_per_row
    input  wire logic                           cfg_we,
    input  wire logic [spt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [spt_pkg::CFG_W-1:0]      cfg_wdata,
    // requests
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,  // mode[2:0], row_index[10:3],
                                                          // col_index[18:11], zero pad
    // results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [23:0]                         m_tdata   // position[12:0], band_width[20:13],
                                                          // status[22:21], zero pad
);

    import spt_pkg::*;

    ctl_cmd_t               cmd;
    dp_stat_t               stat;
    logic [MODE_W-1:0]      mode;
    logic [INDEX_W-1:0]     row_index, col_index;
    logic [POS_W-1:0]       position;
    logic [BAND_W-1:0]      band_width;
    logic [STAT_W-1:0]      status;

    assign mode      = s_tdata[2:0];
    assign row_index = s_tdata[10:3];
    assign col_index = s_tdata[18:11];

    // sequencer; takes a request only when idle
    spt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .mode     (mode),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stores, counters, sort cells and result register
    spt_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .row_index  (row_index),
        .col_index  (col_index),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .position   (position),
        .band_width (band_width),
        .status     (status)
    );

    assign m_tdata = {1'b0, status, band_width, position};

endmodule

`default_nettype wire

// File: rtl/core/spt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/spt_ctrl.sv
// Controller of the sparsity pattern table: sequences clear, add, lookup,
// compress and bandwidth passes. Depends on spt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spt_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [spt_pkg::MODE_W-1:0] mode,
    output logic                            in_ready,
    input  wire spt_pkg::dp_stat_t          stat,
    output spt_pkg::ctl_cmd_t               cmd
);

    import spt_pkg::*;

    state_t state_reg, state_next;
    logic   lookup_reg, lookup_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            lookup_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lookup_reg <= lookup_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        lookup_next = lookup_reg;
        case (state_reg)
            S_INIT:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lookup_next = (mode == MODE_LOOKUP);
                    case (mode)
                        MODE_CLEAR:    state_next = S_CLR;
                        MODE_ADD:      state_next = S_RS0;
                        MODE_LOOKUP:   state_next = S_RS0;
                        MODE_COMPRESS: state_next = S_CP_ROW;
                        MODE_BAND:     state_next = S_BW_ROW;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_CLR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_RS0:
            begin
                state_next = stat.range_ok ? S_RS1 : S_DONE;
            end
            S_RS1:    state_next = S_RS2;
            S_RS2:    state_next = S_RD;
            S_RD:     state_next = S_CHK;
            S_CHK:
            begin
                if (stat.scan_end || (stat.slot_valid && stat.col_hit)
                    || (!stat.slot_valid && !lookup_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_BW_ROW: state_next = stat.row_end ? S_DONE : S_BW_HI;
            S_BW_HI:  state_next = S_BW_RD;
            S_BW_RD:  state_next = S_BW_CHK;
            S_BW_CHK:
            begin
                state_next = (stat.scan_end || !stat.slot_valid) ? S_BW_ROW : S_BW_RD;
            end
            S_CP_ROW:
            begin
                if (stat.packed_set)
                begin
                    state_next = S_DONE;
                end
                else if (stat.row_end)
                begin
                    state_next = S_CP_END;
                end
                else
                begin
                    state_next = S_CP_HI;
                end
            end
            S_CP_HI:  state_next = S_CP_RD;
            S_CP_RD:  state_next = S_CP_CHK;
            S_CP_CHK: state_next = stat.scan_end ? S_CP_WRS : S_CP_RD;
            S_CP_WRS: state_next = S_CP_WR;
            S_CP_WR:  state_next = stat.tmp_done ? S_CP_ROW : S_CP_WR;
            S_CP_END: state_next = S_DONE;
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.rs_sel   = RS_R1;
        cmd.res_kind = RK_NONE;
        in_ready     = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (mode)
                        MODE_CLEAR:    cmd.clr_start = 1'b1;
                        MODE_ADD:      cmd.res_kind  = RK_NONE;
                        MODE_LOOKUP:   cmd.res_kind  = RK_NONE;
                        MODE_COMPRESS: cmd.res_kind  = RK_NONE;
                        MODE_BAND:     cmd.res_kind  = RK_NONE;
                        default:       cmd.res_kind  = RK_ZERO;
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.res_kind = RK_ZERO;
                end
            end
            S_RS0:
            begin
                cmd.rs_sel = RS_ROW;
                if (!stat.range_ok)
                begin
                    cmd.res_kind = lookup_reg ? RK_RANGE_LOOKUP : RK_RANGE_ADD;
                end
            end
            S_RS1:
            begin
                cmd.lo_ld  = 1'b1;
                cmd.rs_sel = RS_ROW1;
            end
            S_RS2:
            begin
                cmd.hi_ld = 1'b1;
            end
            S_CHK:
            begin
                if (stat.scan_end)
                begin
                    cmd.res_kind = lookup_reg ? RK_MISS : RK_FULL;
                end
                else if (stat.slot_valid && stat.col_hit)
                begin
                    cmd.res_kind = lookup_reg ? RK_HIT : RK_ZERO;
                end
                else if (!stat.slot_valid && !lookup_reg)
                begin
                    cmd.add_write = 1'b1;
                    cmd.res_kind  = RK_ZERO;
                end
                else
                begin
                    cmd.a_inc = 1'b1;
                end
            end
            S_BW_ROW:
            begin
                if (stat.row_end)
                begin
                    cmd.res_kind = RK_BAND;
                end
            end
            S_BW_HI:
            begin
                cmd.hi_ld = 1'b1;
            end
            S_BW_CHK:
            begin
                if (stat.scan_end || !stat.slot_valid)
                begin
                    cmd.row_next = 1'b1;
                end
                else
                begin
                    cmd.best_upd = 1'b1;
                    cmd.a_inc    = 1'b1;
                end
            end
            S_CP_ROW:
            begin
                if (stat.packed_set)
                begin
                    cmd.res_kind = RK_ZERO;
                end
            end
            S_CP_HI:
            begin
                cmd.hi_ld = 1'b1;
            end
            S_CP_CHK:
            begin
                if (!stat.scan_end)
                begin
                    cmd.a_inc      = 1'b1;
                    cmd.tmp_insert = stat.slot_valid && !stat.diag_hit;
                end
            end
            S_CP_WRS:
            begin
                cmd.cp_wrs = 1'b1;
            end
            S_CP_WR:
            begin
                if (stat.tmp_done)
                begin
                    cmd.row_next = 1'b1;
                end
                else
                begin
                    cmd.cp_wr = 1'b1;
                end
            end
            S_CP_END:
            begin
                cmd.cp_end   = 1'b1;
                cmd.res_kind = RK_ZERO;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd.res_kind = RK_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/spt_datapath.sv
// Datapath of the sparsity pattern table: column store, row start table,
// scan counters, sort cells and result registers. Depends on spt_pkg, spt_ram.
`timescale 1ns / 1ps
`default_nettype none

module spt_datapath #(
    parameter int MAX_ROWS  = spt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = spt_pkg::DEF_MAX_COLS,
    parameter int MAX_SLOTS = spt_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [spt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [spt_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic [spt_pkg::INDEX_W-1:0]    row_index,
    input  wire logic [spt_pkg::INDEX_W-1:0]    col_index,
    input  wire spt_pkg::ctl_cmd_t              cmd,
    output spt_pkg::dp_stat_t                   stat,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [spt_pkg::POS_W-1:0]           position,
    output logic [spt_pkg::BAND_W-1:0]          band_width,
    output logic [spt_pkg::STAT_W-1:0]          status
);

    import spt_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KW    = $clog2(MAX_COLS + 1);
    localparam int SW    = $clog2(MAX_SLOTS + 1);
    localparam int JW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    localparam logic [RW-1:0] RST_ACT_ROWS =
        RW'(clamp16(16'(RST_ROWS), 16'(MAX_ROWS)));
    localparam logic [KW-1:0] RST_ACT_COLS =
        KW'(clamp16(16'(RST_COLS), 16'(MAX_COLS)));
    localparam logic [SW-1:0] RST_ACT_SLOTS =
        SW'(clamp16(16'(RST_SLOTS), 16'(MAX_SLOTS)));

    // configuration
    logic [CFG_W-1:0]      cfg_rows_reg, cfg_cols_reg;
    logic [SLOT_CFG_W-1:0] cfg_slots_reg;
    logic [RW-1:0]         act_rows_reg;
    logic [KW-1:0]         act_cols_reg;
    logic [SW-1:0]         act_slots_reg;
    logic                  square_reg, packed_reg;

    // item and scan state
    logic [INDEX_W-1:0] row_reg, col_reg;
    logic [RW-1:0]      r_reg;
    logic [SW-1:0]      s_reg, n_reg, j_reg;
    logic [PW-1:0]      a_reg, lo_reg, hi_reg, k_reg;
    logic [CW-1:0]      tmp_reg [MAX_SLOTS];
    logic [BAND_W-1:0]  best_reg;

    // staged and output results
    logic [POS_W-1:0]  res_pos_reg, out_pos_reg;
    logic [BAND_W-1:0] res_band_reg, out_band_reg;
    logic [STAT_W-1:0] res_stat_reg, out_stat_reg;
    logic              out_valid_reg;

    // memories
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [CW:0]   st_wdata, st_rdata;
    logic          rs_we;
    logic [RW-1:0] rs_waddr, rs_raddr;
    logic [PW-1:0] rs_wdata, rs_rdata;

    logic [RW-1:0] clr_rows;
    logic [KW-1:0] clr_cols;
    logic [SW-1:0] clr_slots;
    logic          in_rows, slot_last;
    logic [CW-1:0] st_col;
    logic          st_valid;
    logic [15:0]   dr, dc, row_gap;
    logic [BAND_W-1:0] dist8;
    logic [MAX_SLOTS-1:0] gt;
    logic [CW-1:0] ins [MAX_SLOTS];

    spt_ram #(.WIDTH(CW + 1), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (a_reg[AW-1:0]),
        .rdata (st_rdata)
    );

    spt_ram #(.WIDTH(PW), .DEPTH(MAX_ROWS + 1)) u_row_start (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rs_waddr),
        .wdata (rs_wdata),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

    assign clr_rows  = RW'(clamp16(16'(cfg_rows_reg), 16'(MAX_ROWS)));
    assign clr_cols  = KW'(clamp16(16'(cfg_cols_reg), 16'(MAX_COLS)));
    assign clr_slots = SW'(clamp16(16'(cfg_slots_reg), 16'(MAX_SLOTS)));

    assign in_rows   = (r_reg < act_rows_reg);
    assign slot_last = (s_reg == act_slots_reg - SW'(1));
    assign st_col    = st_rdata[CW-1:0];
    assign st_valid  = st_rdata[CW];

    // distance of the stored column from the current row, saturated
    always_comb
    begin
        dr      = 16'(r_reg);
        dc      = 16'(st_col);
        row_gap = (dr >= dc) ? (dr - dc) : (dc - dr);
        dist8   = (row_gap > 16'd255) ? 8'd255 : row_gap[7:0];
    end

    // insertion sort cells: gt marks slots that move up one place
    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++)
        begin : g_cell
            assign gt[g] = (g >= int'(n_reg)) || (tmp_reg[g] > st_col);
            if (g == 0)
            begin : g_first
                assign ins[g] = gt[g] ? st_col : tmp_reg[g];
            end
            else
            begin : g_rest
                assign ins[g] = !gt[g] ? tmp_reg[g] :
                                (!gt[g-1] ? st_col : tmp_reg[g-1]);
            end
        end
    endgenerate

    // row start read address
    always_comb
    begin
        case (cmd.rs_sel)
            RS_ROW:  rs_raddr = RW'(row_reg);
            RS_ROW1: rs_raddr = RW'(row_reg) + RW'(1);
            RS_R1:   rs_raddr = r_reg + RW'(1);
            default: rs_raddr = r_reg + RW'(1);
        endcase
    end

    // store write port
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = a_reg[AW-1:0];
        st_wdata = {square_reg && (s_reg == '0), CW'(r_reg)};
        if (cmd.clr_step && in_rows)
        begin
            st_we = 1'b1;
        end
        else if (cmd.add_write)
        begin
            st_we    = 1'b1;
            st_wdata = {1'b1, CW'(col_reg)};
        end
        else if (cmd.cp_wrs && square_reg)
        begin
            st_we    = 1'b1;
            st_waddr = k_reg[AW-1:0];
            st_wdata = {1'b1, CW'(r_reg)};
        end
        else if (cmd.cp_wr)
        begin
            st_we    = 1'b1;
            st_waddr = k_reg[AW-1:0];
            st_wdata = {1'b1, tmp_reg[j_reg[JW-1:0]]};
        end
    end

    // row start write port
    always_comb
    begin
        rs_waddr = r_reg;
        rs_wdata = k_reg;
        rs_we    = cmd.cp_wrs || cmd.cp_end;
        if (cmd.clr_step)
        begin
            rs_we    = (s_reg == '0);
            rs_wdata = a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rows_reg  <= RST_ROWS;
            cfg_cols_reg  <= RST_COLS;
            cfg_slots_reg <= RST_SLOTS;
            act_rows_reg  <= RST_ACT_ROWS;
            act_cols_reg  <= RST_ACT_COLS;
            act_slots_reg <= RST_ACT_SLOTS;
            square_reg    <= (16'(RST_ACT_ROWS) == 16'(RST_ACT_COLS));
            packed_reg    <= 1'b0;
            r_reg         <= '0;
            s_reg         <= '0;
            a_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_ROWS:  cfg_rows_reg  <= cfg_wdata;
                    CFG_COLS:  cfg_cols_reg  <= cfg_wdata;
                    CFG_SLOTS: cfg_slots_reg <= cfg_wdata[SLOT_CFG_W-1:0];
                    default:   cfg_rows_reg  <= cfg_rows_reg;
                endcase
            end

            if (cmd.load_item)
            begin
                r_reg <= '0;
            end
            if (cmd.clr_start)
            begin
                act_rows_reg  <= clr_rows;
                act_cols_reg  <= clr_cols;
                act_slots_reg <= clr_slots;
                square_reg    <= (16'(clr_rows) == 16'(clr_cols));
                packed_reg    <= 1'b0;
                s_reg         <= '0;
                a_reg         <= '0;
            end

            if (cmd.clr_step && in_rows)
            begin
                a_reg <= a_reg + PW'(1);
                if (slot_last)
                begin
                    s_reg <= '0;
                    r_reg <= r_reg + RW'(1);
                end
                else
                begin
                    s_reg <= s_reg + SW'(1);
                end
            end

            if (cmd.hi_ld)
            begin
                a_reg <= lo_reg;
            end
            if (cmd.a_inc)
            begin
                a_reg <= a_reg + PW'(1);
            end
            if (cmd.row_next)
            begin
                r_reg <= r_reg + RW'(1);
            end
            if (cmd.cp_end)
            begin
                packed_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            row_reg  <= row_index;
            col_reg  <= col_index;
            lo_reg   <= '0;
            best_reg <= '0;
            k_reg    <= '0;
        end
        if (cmd.lo_ld)
        begin
            lo_reg <= rs_rdata;
        end
        if (cmd.hi_ld)
        begin
            hi_reg <= rs_rdata;
            n_reg  <= '0;
        end
        if (cmd.row_next)
        begin
            lo_reg <= hi_reg;
        end
        if (cmd.best_upd && (dist8 > best_reg))
        begin
            best_reg <= dist8;
        end
        if (cmd.tmp_insert)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                tmp_reg[i] <= ins[i];
            end
            n_reg <= n_reg + SW'(1);
        end
        if (cmd.cp_wrs)
        begin
            j_reg <= '0;
            k_reg <= square_reg ? (k_reg + PW'(1)) : k_reg;
        end
        if (cmd.cp_wr)
        begin
            j_reg <= j_reg + SW'(1);
            k_reg <= k_reg + PW'(1);
        end

        case (cmd.res_kind)
            RK_NONE:
            begin
                res_stat_reg <= res_stat_reg;
            end
            RK_ZERO:
            begin
                res_pos_reg  <= '0;
                res_band_reg <= '0;
                res_stat_reg <= ST_OK;
            end
            RK_RANGE_ADD:
            begin
                res_pos_reg  <= '0;
                res_band_reg <= '0;
                res_stat_reg <= ST_RANGE;
            end
            RK_RANGE_LOOKUP:
            begin
                res_pos_reg  <= '1;
                res_band_reg <= '0;
                res_stat_reg <= ST_RANGE;
            end
            RK_FULL:
            begin
                res_pos_reg  <= '0;
                res_band_reg <= '0;
                res_stat_reg <= ST_FULL;
            end
            RK_HIT:
            begin
                res_pos_reg  <= POS_W'(a_reg);
                res_band_reg <= '0;
                res_stat_reg <= ST_OK;
            end
            RK_MISS:
            begin
                res_pos_reg  <= '1;
                res_band_reg <= '0;
                res_stat_reg <= ST_OK;
            end
            RK_BAND:
            begin
                res_pos_reg  <= '0;
                res_band_reg <= best_reg;
                res_stat_reg <= ST_OK;
            end
            default:
            begin
                res_stat_reg <= res_stat_reg;
            end
        endcase

        if (cmd.out_load)
        begin
            out_pos_reg  <= res_pos_reg;
            out_band_reg <= res_band_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign stat.clr_last   = !in_rows;
    assign stat.range_ok   = (16'(row_reg) < 16'(act_rows_reg))
                             && (16'(col_reg) < 16'(act_cols_reg));
    assign stat.scan_end   = (a_reg >= hi_reg);
    assign stat.slot_valid = st_valid;
    assign stat.col_hit    = (st_col == CW'(col_reg));
    assign stat.diag_hit   = square_reg && (st_col == CW'(r_reg));
    assign stat.row_end    = (r_reg == act_rows_reg);
    assign stat.tmp_done   = (j_reg == n_reg);
    assign stat.packed_set = packed_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign position   = out_pos_reg;
    assign band_width = out_band_reg;
    assign status     = out_stat_reg;

endmodule

`default_nettype wire

// File: rtl/core/spt_checker.sv
// Port-level checks for the sparsity pattern table, bound to the top level.
// Depends on spt_pkg and sparsity_pattern_table.
`timescale 1ns / 1ps
`default_nettype none

module spt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    import spt_pkg::*;

    // a result waiting for the sink is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // one request in flight: ready drops after a request is taken
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // an error status carries no bandwidth
    a_err_band: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[22:21] != ST_OK) |-> m_tdata[20:13] == 8'd0)
        else $error("bandwidth set with an error status");

    // a full row reports no position
    a_full_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[22:21] == ST_FULL) |-> m_tdata[12:0] == 13'd0)
        else $error("position set on a row-full result");

    // a bandwidth result has no position
    a_band_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[20:13] != 8'd0) |-> m_tdata[12:0] == 13'd0)
        else $error("bandwidth and position both set");

endmodule

bind sparsity_pattern_table spt_checker u_spt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
